// File: sv/wtc_pkg.sv
// ----------------------------------------------------------------------------
// wtc_pkg
// Shared types and constants for the weighted texture compositor.
// ----------------------------------------------------------------------------
package wtc_pkg;

   localparam int BYTE_W    = 8;
   localparam int PIXEL_W   = 32;
   localparam int WEIGHT_W  = 9;
   localparam int MODE_W    = 2;
   localparam int LANES     = 3;
   localparam int CSR_IDX_W = 4;
   localparam int PROD_W    = BYTE_W + WEIGHT_W;
   localparam int SUM_W     = PROD_W + 2;
   localparam int TAT_W     = 2 * BYTE_W + 1;

   localparam logic [BYTE_W-1:0] BYTE_MAX = 8'hFF;

   typedef logic [MODE_W-1:0]   mode_type;
   typedef logic [WEIGHT_W-1:0] weight_type;
   typedef logic [BYTE_W-1:0]   byte_type;
   typedef logic [PIXEL_W-1:0]  pixel_type;

   // blend modes
   localparam mode_type MODE_OVERLAY = 2'd0;
   localparam mode_type MODE_BLEND2  = 2'd1;
   localparam mode_type MODE_BLEND3  = 2'd2;
   localparam mode_type MODE_TATTOO  = 2'd3;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_BLEND_MODE    = 4'd0;
   localparam logic [CSR_IDX_W-1:0] REG_WEIGHT_DEST   = 4'd1;
   localparam logic [CSR_IDX_W-1:0] REG_WEIGHT_FIRST  = 4'd2;
   localparam logic [CSR_IDX_W-1:0] REG_WEIGHT_SECOND = 4'd3;

   localparam weight_type WEIGHT_ONE = 9'd256;

   typedef struct packed {
      mode_type   mode;
      weight_type weight_dest;
      weight_type weight_first;
      weight_type weight_second;
   } lane_cfg_type;

endpackage

// File: sv/wtc_lane.sv
// ----------------------------------------------------------------------------
// wtc_lane
// One colour byte: weighted sum with saturation, then tattoo interpolation.
// ----------------------------------------------------------------------------
module wtc_lane (
   input  logic                  clock,
   input  logic                  advance,
   input  wtc_pkg::lane_cfg_type cfg,
   input  wtc_pkg::byte_type     dest_byte,
   input  wtc_pkg::byte_type     first_byte,
   input  wtc_pkg::byte_type     second_byte,
   input  wtc_pkg::byte_type     tattoo_byte,
   input  wtc_pkg::byte_type     tattoo_alpha,
   output wtc_pkg::byte_type     lane_byte
);

   // stage 1: weight products
   logic [wtc_pkg::PROD_W-1:0] prod_dest_ff, prod_first_ff, prod_second_ff;
   wtc_pkg::byte_type          tat1_ff, alpha1_ff;

   // stage 2: saturated blend byte
   logic [wtc_pkg::SUM_W-1:0]   sum_in;
   logic [wtc_pkg::SUM_W-9:0]   sum_shift;
   wtc_pkg::byte_type           blend_in;
   wtc_pkg::byte_type           blend2_ff, tat2_ff, alpha2_ff;

   // stage 3: interpolation products
   logic [2*wtc_pkg::BYTE_W-1:0] prod_blend_ff, prod_tat_ff;
   wtc_pkg::byte_type            blend3_ff;
   wtc_pkg::byte_type            inv_alpha;

   logic [wtc_pkg::TAT_W-1:0] mix;
   logic [wtc_pkg::TAT_W-1:0] div_acc;
   wtc_pkg::byte_type         quot;

   always_ff @(posedge clock) begin
      if (advance) begin
         prod_dest_ff   <= wtc_pkg::PROD_W'(dest_byte)   * wtc_pkg::PROD_W'(cfg.weight_dest);
         prod_first_ff  <= wtc_pkg::PROD_W'(first_byte)  * wtc_pkg::PROD_W'(cfg.weight_first);
         prod_second_ff <= wtc_pkg::PROD_W'(second_byte) * wtc_pkg::PROD_W'(cfg.weight_second);
         tat1_ff        <= tattoo_byte;
         alpha1_ff      <= tattoo_alpha;
      end
   end

   always_comb begin
      sum_in = wtc_pkg::SUM_W'(prod_dest_ff) + wtc_pkg::SUM_W'(prod_first_ff);
      if (cfg.mode == wtc_pkg::MODE_BLEND3 || cfg.mode == wtc_pkg::MODE_TATTOO) begin
         sum_in = sum_in + wtc_pkg::SUM_W'(prod_second_ff);
      end
      sum_shift = sum_in[wtc_pkg::SUM_W-1:8];
      // saturate anything past one byte
      if (|sum_shift[wtc_pkg::SUM_W-9:wtc_pkg::BYTE_W]) begin
         blend_in = wtc_pkg::BYTE_MAX;
      end else begin
         blend_in = sum_shift[wtc_pkg::BYTE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         blend2_ff <= blend_in;
         tat2_ff   <= tat1_ff;
         alpha2_ff <= alpha1_ff;
      end
   end

   assign inv_alpha = wtc_pkg::BYTE_MAX - alpha2_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         prod_blend_ff <= 16'(blend2_ff) * 16'(inv_alpha);
         prod_tat_ff   <= 16'(tat2_ff) * 16'(alpha2_ff);
         blend3_ff     <= blend2_ff;
      end
   end

   // exact floor(x / 255) for x up to 255 * 255: (x + (x >> 8) + 1) >> 8
   always_comb begin
      mix     = wtc_pkg::TAT_W'(prod_blend_ff) + wtc_pkg::TAT_W'(prod_tat_ff);
      div_acc = mix + wtc_pkg::TAT_W'(mix[15:8]) + wtc_pkg::TAT_W'(1);
      quot    = div_acc[15:8];
   end

   assign lane_byte = (cfg.mode == wtc_pkg::MODE_TATTOO) ? quot : blend3_ff;

endmodule

// File: sv/wtc_merge.sv
// ----------------------------------------------------------------------------
// wtc_merge
// Combines the lane bytes with destination alpha, or picks the overlay pixel.
// ----------------------------------------------------------------------------
module wtc_merge (
   input  wtc_pkg::mode_type                    mode,
   input  wtc_pkg::pixel_type                   dest_pixel,
   input  wtc_pkg::pixel_type                   first_pixel,
   input  logic [wtc_pkg::LANES*wtc_pkg::BYTE_W-1:0] lane_bytes,
   output wtc_pkg::pixel_type                   result_pixel
);

   always_comb begin
      if (mode == wtc_pkg::MODE_OVERLAY) begin
         // first source wins where its alpha is nonzero
         if (|first_pixel[wtc_pkg::PIXEL_W-1:wtc_pkg::LANES*wtc_pkg::BYTE_W]) begin
            result_pixel = first_pixel;
         end else begin
            result_pixel = dest_pixel;
         end
      end else begin
         result_pixel = {dest_pixel[wtc_pkg::PIXEL_W-1:wtc_pkg::LANES*wtc_pkg::BYTE_W],
                         lane_bytes};
      end
   end

endmodule

// File: sv/weighted_texture_compositor.sv
// ----------------------------------------------------------------------------
// weighted_texture_compositor
// RGBA8888 compositor: overlay, two/three-way weighted blend, tattoo blend.
// ----------------------------------------------------------------------------
//  channel | direction | handshake             | payload
//  req     | in        | req_tvalid/req_tready | dest, first, second, tattoo pixels
//  rsp     | out       | rsp_tvalid/rsp_tready | result pixel
//  csr     | in        | csr_we                | csr_index, csr_wdata
//
//  one pixel per cycle sustained while rsp_tready allows; four register stages, the
//  last of them holding the result pixel
//  three colour lanes run side by side, each a multiply, saturate, multiply chain
//  a stalled result holds the whole pipeline; req_tready follows the output slot
//  synchronous reset clears valids and restores register defaults
// ----------------------------------------------------------------------------
module weighted_texture_compositor (
   input  logic                              clock,
   input  logic                              reset,
   // dest_pixel, first_pixel, second_pixel, tattoo_pixel
   input  logic [4*wtc_pkg::PIXEL_W-1:0]     req_tdata,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // result_pixel
   output logic [wtc_pkg::PIXEL_W-1:0]       rsp_tdata,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   input  logic                              csr_we,
   input  logic [wtc_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [wtc_pkg::WEIGHT_W-1:0]      csr_wdata
);

   localparam int PW = wtc_pkg::PIXEL_W;
   localparam int BW = wtc_pkg::BYTE_W;

   wtc_pkg::lane_cfg_type cfg_ff;
   logic                  advance;
   logic                  v1_ff, v2_ff, v3_ff, out_valid_ff;
   wtc_pkg::pixel_type    dest1_ff, dest2_ff, dest3_ff;
   wtc_pkg::pixel_type    first1_ff, first2_ff, first3_ff;
   wtc_pkg::pixel_type    result_in, result_ff;
   logic [wtc_pkg::LANES*BW-1:0] lane_bytes;

   wtc_pkg::pixel_type dest_px, first_px, second_px, tattoo_px;

   assign dest_px   = req_tdata[PW-1:0];
   assign first_px  = req_tdata[2*PW-1:PW];
   assign second_px = req_tdata[3*PW-1:2*PW];
   assign tattoo_px = req_tdata[4*PW-1:3*PW];

   // register file
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.mode          <= wtc_pkg::MODE_OVERLAY;
         cfg_ff.weight_dest   <= wtc_pkg::WEIGHT_ONE;
         cfg_ff.weight_first  <= '0;
         cfg_ff.weight_second <= '0;
      end else if (csr_we) begin
         unique case (csr_index)
            wtc_pkg::REG_BLEND_MODE:    cfg_ff.mode <= csr_wdata[wtc_pkg::MODE_W-1:0];
            wtc_pkg::REG_WEIGHT_DEST:   cfg_ff.weight_dest <= csr_wdata;
            wtc_pkg::REG_WEIGHT_FIRST:  cfg_ff.weight_first <= csr_wdata;
            wtc_pkg::REG_WEIGHT_SECOND: cfg_ff.weight_second <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign advance    = !out_valid_ff || rsp_tready;
   assign req_tready = advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         v1_ff        <= req_tvalid;
         v2_ff        <= v1_ff;
         v3_ff        <= v2_ff;
         out_valid_ff <= v3_ff;
      end
   end

   // pixels needed by the merge ride alongside the lanes
   always_ff @(posedge clock) begin
      if (advance) begin
         dest1_ff  <= dest_px;
         dest2_ff  <= dest1_ff;
         dest3_ff  <= dest2_ff;
         first1_ff <= first_px;
         first2_ff <= first1_ff;
         first3_ff <= first2_ff;
         result_ff <= result_in;
      end
   end

   for (genvar k = 0; k < wtc_pkg::LANES; k++) begin : g_lane
      wtc_lane u_lane (
         .clock        (clock),
         .advance      (advance),
         .cfg          (cfg_ff),
         .dest_byte    (dest_px[k*BW +: BW]),
         .first_byte   (first_px[k*BW +: BW]),
         .second_byte  (second_px[k*BW +: BW]),
         .tattoo_byte  (tattoo_px[k*BW +: BW]),
         .tattoo_alpha (tattoo_px[PW-1 -: BW]),
         .lane_byte    (lane_bytes[k*BW +: BW])
      );
   end

   wtc_merge u_merge (
      .mode         (cfg_ff.mode),
      .dest_pixel   (dest3_ff),
      .first_pixel  (first3_ff),
      .lane_bytes   (lane_bytes),
      .result_pixel (result_in)
   );

   assign rsp_tdata  = result_ff;
   assign rsp_tvalid = out_valid_ff;

endmodule

// File: verif/tb_weighted_texture_compositor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_weighted_texture_compositor
// Streams pixel sets through the compositor under a series of register
// settings. Each accepted set is predicted here and checked against the
// result stream in order. Both handshakes idle at random, with one long
// result stall.
// ----------------------------------------------------------------------------
module tb_weighted_texture_compositor;

   localparam int RANDOM_PHASES = 12;
   localparam int PHASE_ITEMS   = 150;
   localparam int STEADY_PHASE  = 5;
   localparam int LIMIT_CYCLES  = 200000;
   localparam int HOLD_AT       = 600;
   localparam int HOLD_CYCLES   = 120;
   localparam int TAIL_CYCLES   = 20;
   localparam int FIRST_UNUSED_REG = int'(wtc_pkg::REG_WEIGHT_SECOND) + 1;

   // dest pixel in the low word, tattoo in the high word
   typedef struct packed {
      wtc_pkg::pixel_type tattoo;
      wtc_pkg::pixel_type second;
      wtc_pkg::pixel_type first;
      wtc_pkg::pixel_type dest;
   } texel_set_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   // dest_pixel, first_pixel, second_pixel, tattoo_pixel
   logic [4*wtc_pkg::PIXEL_W-1:0]  req_tdata  = '0;
   logic                           req_tvalid = 1'b0;
   logic                           req_tready;
   // result_pixel
   logic [wtc_pkg::PIXEL_W-1:0]    rsp_tdata;
   logic                           rsp_tvalid;
   logic                           rsp_tready = 1'b0;
   logic                           csr_we     = 1'b0;
   logic [wtc_pkg::CSR_IDX_W-1:0]  csr_index  = '0;
   logic [wtc_pkg::WEIGHT_W-1:0]   csr_wdata  = '0;

   // register copies as the block should hold them
   wtc_pkg::mode_type   cfg_mode     = wtc_pkg::MODE_OVERLAY;
   wtc_pkg::weight_type cfg_w_dest   = wtc_pkg::WEIGHT_ONE;
   wtc_pkg::weight_type cfg_w_first  = '0;
   wtc_pkg::weight_type cfg_w_second = '0;

   texel_set_type      texel_feed[$];
   wtc_pkg::pixel_type composited_q[$];
   wtc_pkg::pixel_type front_pixel;
   bit         steady = 1'b0;
   int         hold_left = 0;
   int         rsp_total = 0;
   int         error_count = 0;
   int         cycle_count = 0;

   weighted_texture_compositor DUT (
      .clock(clock),
      .reset(reset),
      .req_tdata(req_tdata),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   always #2 clock = ~clock;

   function automatic wtc_pkg::pixel_type composite_pixel(texel_set_type px);
      wtc_pkg::pixel_type res;
      int unsigned sum;
      int unsigned lane;
      int unsigned ta;
      if (cfg_mode == wtc_pkg::MODE_OVERLAY) begin
         res = (px.first[31:24] != 0) ? px.first : px.dest;
      end else begin
         ta  = px.tattoo[31:24];
         res = {px.dest[31:24], 24'h0};
         for (int k = 0; k < wtc_pkg::LANES; k++) begin
            sum = px.dest[8*k +: 8] * cfg_w_dest + px.first[8*k +: 8] * cfg_w_first;
            if (cfg_mode == wtc_pkg::MODE_BLEND3 || cfg_mode == wtc_pkg::MODE_TATTOO)
               sum += px.second[8*k +: 8] * cfg_w_second;
            lane = sum >> 8;
            if (lane > wtc_pkg::BYTE_MAX)
               lane = wtc_pkg::BYTE_MAX;
            // pull toward the tattoo byte by tattoo alpha / 255
            if (cfg_mode == wtc_pkg::MODE_TATTOO)
               lane = (lane * (wtc_pkg::BYTE_MAX - ta) + px.tattoo[8*k +: 8] * ta)
                      / wtc_pkg::BYTE_MAX;
            res[8*k +: 8] = lane[7:0];
         end
      end
      return res;
   endfunction

   function automatic wtc_pkg::pixel_type random_pixel();
      unique case ($urandom_range(7))
         0: return '0;
         1: return '1;
         2: return {8'h00, 24'($urandom)};
         3: return {8'hFF, 24'($urandom)};
         default: return $urandom;
      endcase
   endfunction

   function automatic wtc_pkg::weight_type random_weight();
      unique case ($urandom_range(4))
         0: return '0;
         1: return wtc_pkg::WEIGHT_ONE;
         2: return '1;
         default: return wtc_pkg::weight_type'($urandom_range(511));
      endcase
   endfunction

   task automatic push_texels(wtc_pkg::pixel_type d, wtc_pkg::pixel_type f,
                              wtc_pkg::pixel_type s, wtc_pkg::pixel_type t);
      texel_feed.push_back('{tattoo: t, second: s, first: f, dest: d});
   endtask

   task automatic write_reg(logic [wtc_pkg::CSR_IDX_W-1:0] idx, wtc_pkg::weight_type val);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      unique case (idx)
         wtc_pkg::REG_BLEND_MODE:    cfg_mode     = val[wtc_pkg::MODE_W-1:0];
         wtc_pkg::REG_WEIGHT_DEST:   cfg_w_dest   = val;
         wtc_pkg::REG_WEIGHT_FIRST:  cfg_w_first  = val;
         wtc_pkg::REG_WEIGHT_SECOND: cfg_w_second = val;
         default: ;
      endcase
   endtask

   // upper mode bits are junk the block must drop; a stray index must not land
   task automatic apply_setting(wtc_pkg::mode_type mode, wtc_pkg::weight_type wd,
                                wtc_pkg::weight_type wf, wtc_pkg::weight_type ws);
      write_reg(wtc_pkg::REG_BLEND_MODE, {7'($urandom), mode});
      write_reg(wtc_pkg::REG_WEIGHT_DEST, wd);
      write_reg(wtc_pkg::REG_WEIGHT_FIRST, wf);
      write_reg(wtc_pkg::REG_WEIGHT_SECOND, ws);
      write_reg(wtc_pkg::CSR_IDX_W'($urandom_range(2**wtc_pkg::CSR_IDX_W - 1,
                                                   FIRST_UNUSED_REG)),
                wtc_pkg::weight_type'($urandom));
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic drain();
      do
         @(negedge clock);
      while (texel_feed.size() != 0 || req_tvalid || composited_q.size() != 0);
   endtask

   // driver: a set is accepted when req_tvalid and req_tready meet at an edge
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         if (req_tvalid)
            composited_q.push_back(composite_pixel(texel_set_type'(req_tdata)));
         if (texel_feed.size() != 0 && (steady || $urandom_range(99) >= 15)) begin
            req_tdata  <= texel_feed.pop_front();
            req_tvalid <= 1'b1;
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // monitor: checks each result transfer, stalls at random and once for long
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (composited_q.size() == 0) begin
               $error("result_pixel: unexpected transfer %h", rsp_tdata);
               error_count++;
            end else begin
               front_pixel = composited_q.pop_front();
               if (rsp_tdata !== front_pixel) begin
                  $error("result_pixel: expected %h, actual %h", front_pixel, rsp_tdata);
                  error_count++;
               end
            end
            rsp_total++;
            if (rsp_total == HOLD_AT)
               hold_left = HOLD_CYCLES;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= steady || $urandom_range(99) >= 15;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == LIMIT_CYCLES) begin
         $display("simulation failed");
         $finish;
      end
   end

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // overlay under reset defaults: first alpha decides
      push_texels(32'h12345678, 32'h00FFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF);
      push_texels(32'h12345678, 32'h01000000, 32'h0, 32'h0);
      push_texels(32'hFFFFFFFF, 32'hFF00FF00, 32'h0, 32'h0);
      push_texels(32'h0, 32'h0, 32'h0, 32'h0);
      push_texels(32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF);
      drain();

      // two-way blend with maximum weights saturates
      apply_setting(wtc_pkg::MODE_BLEND2, '1, '1, '1);
      push_texels(32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF);
      push_texels(32'h80000000, 32'h0, 32'hFFFFFFFF, 32'h0);
      push_texels(32'h7F102030, 32'h00010203, 32'hAAAAAAAA, 32'h55555555);
      drain();

      apply_setting(wtc_pkg::MODE_BLEND3, wtc_pkg::WEIGHT_ONE, 9'd128, 9'd128);
      push_texels(32'h40FF8001, 32'hFF01FF80, 32'hFFFFFFFF, 32'h0);
      push_texels(32'h00000000, 32'h00FFFFFF, 32'h00FFFFFF, 32'hFFFFFFFF);
      push_texels(32'hC0112233, 32'h44556677, 32'h8899AABB, 32'h0);
      drain();

      apply_setting(wtc_pkg::MODE_BLEND3, '0, '0, '0);
      push_texels(32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF);
      push_texels(32'h5A123456, 32'h0, 32'h0, 32'h0);
      drain();

      // tattoo alpha at zero, full and half
      apply_setting(wtc_pkg::MODE_TATTOO, wtc_pkg::WEIGHT_ONE, '0, '0);
      push_texels(32'h33A0B0C0, 32'h0, 32'h0, 32'h00FFFFFF);
      push_texels(32'h33A0B0C0, 32'h0, 32'h0, 32'hFF102030);
      push_texels(32'hFFFFFFFF, 32'h0, 32'h0, 32'h80000000);
      push_texels(32'h01FF00FF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'h7F00FF00);
      drain();

      apply_setting(wtc_pkg::MODE_TATTOO, '1, '1, '1);
      push_texels(32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'h01000000);
      push_texels(32'h80808080, 32'h80808080, 32'h80808080, 32'hFE010203);
      drain();

      // overlay ignores the weights
      apply_setting(wtc_pkg::MODE_OVERLAY, random_weight(), random_weight(),
                    random_weight());
      push_texels(32'hDEADBEEF, 32'h00C0FFEE, 32'h0, 32'h0);
      push_texels(32'hDEADBEEF, 32'h80C0FFEE, 32'h0, 32'h0);
      drain();

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         apply_setting(wtc_pkg::mode_type'($urandom_range(3)), random_weight(),
                       random_weight(), random_weight());
         steady = (p == STEADY_PHASE);
         for (int n = 0; n < PHASE_ITEMS; n++)
            push_texels(random_pixel(), random_pixel(), random_pixel(), random_pixel());
         drain();
      end
      steady = 1'b0;

      repeat (TAIL_CYCLES) @(posedge clock);
      if (composited_q.size() != 0) begin
         $error("result_pixel: %0d results never arrived", composited_q.size());
         error_count++;
      end
      if (error_count == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
